@@ rtl/qwt_pkg.sv @@
// ----------------------------------------------------------------------------
// Quoted whitespace line tokenizer package
// Shared result types, result kinds, error codes and character constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qwt_pkg;

  localparam logic [1:0] KIND_TOKEN    = 2'd0;
  localparam logic [1:0] KIND_LINE_END = 2'd1;
  localparam logic [1:0] KIND_END      = 2'd2;
  localparam logic [1:0] KIND_ERROR    = 2'd3;

  localparam logic [1:0] ERR_INCOMPLETE = 2'd0;
  localparam logic [1:0] ERR_QUOTE      = 2'd1;
  localparam logic [1:0] ERR_LONG       = 2'd2;

  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;

  localparam logic REG_MAX_LINE_BYTES = 1'b0;
  localparam logic [12:0] MAX_LINE_BYTES_RESET = 13'd4096;

  localparam int QDEPTH = 4;
  localparam int QPW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] token_start;
    logic [12:0] token_length;
    logic        quoted;
    logic [11:0] token_count;
    logic [31:0] line_number;
    logic [1:0]  error_code;
    logic        last;
  } res_t;

  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } ent_t;

endpackage

`default_nettype wire

@@ rtl/qwt_ifs.sv @@
// ----------------------------------------------------------------------------
// Quoted whitespace line tokenizer channels
// Valid/ready channel interfaces for input items and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface qwt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface qwt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [11:0] token_start;
  logic [12:0] token_length;
  logic        quoted;
  logic [11:0] token_count;
  logic [31:0] line_number;
  logic [1:0]  error_code;
  logic        last;

  modport source (output valid, output kind, output token_start, output token_length,
                  output quoted, output token_count, output line_number,
                  output error_code, output last, input ready);
  modport sink (input valid, input kind, input token_start, input token_length,
                input quoted, input token_count, input line_number,
                input error_code, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/qwt_front.sv @@
// ----------------------------------------------------------------------------
// Tokenizer front end
// Accepts one byte per cycle while the queue is not full, updates the scan state and packs the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qwt_front #(
  parameter int MAX_LINE = 4096
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [12:0]   max_line_bytes,
  qwt_in_if.sink             in_ch,
  input  wire logic          q_full,
  output logic               q_push,
  output qwt_pkg::ent_t      q_wdata
);
  import qwt_pkg::*;

  localparam int LW = $clog2(MAX_LINE + 1);
  localparam int CW = (LW > 13) ? LW : 13;

  typedef enum logic [5:0] {
    S_BETWEEN  = 6'b000001,
    S_UNQUOTED = 6'b000010,
    S_QUOTED   = 6'b000100,
    S_AFTER_CR = 6'b001000,
    S_ENDED    = 6'b010000,
    S_ERROR    = 6'b100000
  } mode_t;

  mode_t          mode_r, mode_nxt, cur;
  logic [1:0]     err_r, err_nxt;
  logic [LW-1:0]  col_r, col_nxt;
  logic [LW-1:0]  tb_r, tb_nxt;
  logic           bs_r, bs_nxt;
  logic [11:0]    tok_r, tok_nxt, tok_inc;
  logic [31:0]    line_r, line_nxt, line_inc;
  logic [CW-1:0]  cfg_w, lim, col_w;
  logic [7:0]     b;
  logic           eoi, eol, blank, skip, accept;
  logic [1:0]     nres;
  res_t           base, r0, r1, tok_rec;

  assign b       = in_ch.data_byte;
  assign eoi     = in_ch.end_of_input;
  assign eol     = (b == CH_CR) || (b == CH_LF);
  assign blank   = (b == CH_SPACE) || (b == CH_TAB);
  assign tok_inc = (tok_r == 12'hFFF) ? tok_r : tok_r + 12'd1;
  assign line_inc = (line_r == 32'hFFFF_FFFF) ? line_r : line_r + 32'd1;
  assign cfg_w   = CW'(max_line_bytes);
  assign col_w   = CW'(col_r);

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  always_comb begin
    if (cfg_w == '0) begin
      lim = CW'(1);
    end else if (cfg_w > CW'(MAX_LINE)) begin
      lim = CW'(MAX_LINE);
    end else begin
      lim = cfg_w;
    end
  end

  always_comb begin
    base             = '0;
    base.line_number = line_r;
    tok_rec              = base;
    tok_rec.kind         = KIND_TOKEN;
    tok_rec.token_start  = 12'(tb_r);
    tok_rec.token_length = 13'(col_r - tb_r);
    tok_rec.token_count  = tok_r;
  end

  always_comb begin
    mode_nxt = mode_r;
    err_nxt  = err_r;
    col_nxt  = col_r;
    tb_nxt   = tb_r;
    bs_nxt   = bs_r;
    tok_nxt  = tok_r;
    line_nxt = line_r;
    r0       = base;
    r1       = base;
    nres     = 2'd0;
    cur      = mode_r;
    skip     = 1'b0;
    if (mode_r == S_ERROR) begin
      r0.kind       = KIND_ERROR;
      r0.error_code = err_r;
      nres          = 2'd1;
    end else if (mode_r == S_ENDED) begin
      if (eoi) begin
        r0.kind = KIND_END;
        nres    = 2'd1;
      end
    end else if (eoi) begin
      nres = 2'd1;
      if ((mode_r == S_BETWEEN || mode_r == S_AFTER_CR) && col_r == '0) begin
        mode_nxt = S_ENDED;
        r0.kind  = KIND_END;
      end else begin
        mode_nxt      = S_ERROR;
        err_nxt       = ERR_INCOMPLETE;
        r0.kind       = KIND_ERROR;
        r0.error_code = ERR_INCOMPLETE;
      end
    end else begin
      if (mode_r == S_AFTER_CR) begin
        cur      = S_BETWEEN;
        mode_nxt = S_BETWEEN;
        skip     = (b == CH_LF);
      end
      if (!skip) begin
        if (!eol && col_w >= lim) begin
          mode_nxt      = S_ERROR;
          err_nxt       = ERR_LONG;
          r0.kind       = KIND_ERROR;
          r0.error_code = ERR_LONG;
          nres          = 2'd1;
        end else begin
          case (cur)
            S_BETWEEN: begin
              if (eol) begin
                r0.kind        = KIND_LINE_END;
                r0.token_count = tok_r;
                nres           = 2'd1;
                line_nxt       = line_inc;
                tok_nxt        = '0;
                col_nxt        = '0;
                mode_nxt       = (b == CH_CR) ? S_AFTER_CR : S_BETWEEN;
              end else if (blank) begin
                col_nxt = col_r + LW'(1);
              end else if (b == CH_QUOTE) begin
                mode_nxt = S_QUOTED;
                tb_nxt   = col_r + LW'(1);
                bs_nxt   = 1'b0;
                col_nxt  = col_r + LW'(1);
              end else begin
                mode_nxt = S_UNQUOTED;
                tb_nxt   = col_r;
                col_nxt  = col_r + LW'(1);
              end
            end
            S_UNQUOTED: begin
              if (blank) begin
                r0       = tok_rec;
                nres     = 2'd1;
                tok_nxt  = tok_inc;
                mode_nxt = S_BETWEEN;
                col_nxt  = col_r + LW'(1);
              end else if (eol) begin
                r0             = tok_rec;
                r1.kind        = KIND_LINE_END;
                r1.token_count = tok_inc;
                nres           = 2'd2;
                line_nxt       = line_inc;
                tok_nxt        = '0;
                col_nxt        = '0;
                mode_nxt       = (b == CH_CR) ? S_AFTER_CR : S_BETWEEN;
              end else begin
                col_nxt = col_r + LW'(1);
              end
            end
            S_QUOTED: begin
              if (eol) begin
                mode_nxt      = S_ERROR;
                err_nxt       = ERR_QUOTE;
                r0.kind       = KIND_ERROR;
                r0.error_code = ERR_QUOTE;
                nres          = 2'd1;
              end else if (b == CH_QUOTE && !bs_r) begin
                r0        = tok_rec;
                r0.quoted = 1'b1;
                nres      = 2'd1;
                tok_nxt   = tok_inc;
                mode_nxt  = S_BETWEEN;
                col_nxt   = col_r + LW'(1);
              end else begin
                bs_nxt  = (b == CH_BACKSLASH);
                col_nxt = col_r + LW'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
    r0.last = (nres == 2'd1);
    r1.last = 1'b1;
  end

  assign q_push     = accept && (nres != 2'd0);
  assign q_wdata.two = (nres == 2'd2);
  assign q_wdata.r0  = r0;
  assign q_wdata.r1  = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= S_BETWEEN;
      err_r  <= ERR_INCOMPLETE;
      col_r  <= '0;
      tb_r   <= '0;
      bs_r   <= 1'b0;
      tok_r  <= '0;
      line_r <= 32'd1;
    end else if (accept) begin
      mode_r <= mode_nxt;
      err_r  <= err_nxt;
      col_r  <= col_nxt;
      tb_r   <= tb_nxt;
      bs_r   <= bs_nxt;
      tok_r  <= tok_nxt;
      line_r <= line_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/qwt_queue.sv @@
// ----------------------------------------------------------------------------
// Tokenizer result queue
// Short first-in first-out queue of result pairs between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qwt_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire qwt_pkg::ent_t wdata,
  input  wire logic          pop,
  output logic               full,
  output logic               empty,
  output qwt_pkg::ent_t      rdata
);
  import qwt_pkg::*;

  ent_t           mem [QDEPTH];
  logic [QPW-1:0] wp_r, rp_r;
  logic [QPW:0]   cnt_r;

  assign full  = (cnt_r == (QPW + 1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + QPW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + QPW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (QPW + 1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (QPW + 1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/qwt_back.sv @@
// ----------------------------------------------------------------------------
// Tokenizer back end
// Unpacks result pairs from the queue into a registered output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qwt_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_empty,
  input  wire qwt_pkg::ent_t q_rdata,
  output logic               q_pop,
  qwt_out_if.source          out_ch
);
  import qwt_pkg::*;

  logic out_valid_r;
  logic pend_r;
  res_t out_r;
  res_t sec_r;
  logic load;

  assign load  = !out_valid_r || out_ch.ready;
  assign q_pop = load && !pend_r && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else if (load) begin
      if (pend_r) begin
        out_valid_r <= 1'b1;
        pend_r      <= 1'b0;
      end else if (!q_empty) begin
        out_valid_r <= 1'b1;
        pend_r      <= q_rdata.two;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_r) begin
        out_r <= sec_r;
      end else begin
        out_r <= q_rdata.r0;
        sec_r <= q_rdata.r1;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_r.kind;
  assign out_ch.token_start  = out_r.token_start;
  assign out_ch.token_length = out_r.token_length;
  assign out_ch.quoted       = out_r.quoted;
  assign out_ch.token_count  = out_r.token_count;
  assign out_ch.line_number  = out_r.line_number;
  assign out_ch.error_code   = out_r.error_code;
  assign out_ch.last         = out_r.last;

endmodule

`default_nettype wire

@@ rtl/quoted_whitespace_line_tokenizer.sv @@
// ----------------------------------------------------------------------------
// Quoted whitespace line tokenizer
// Splits a byte stream into space or tab separated tokens and quoted strings.
// ----------------------------------------------------------------------------
// The block takes one text byte per item on in_ch and returns token, line end,
// end of input and error items on out_ch, with up to two items per byte.
// The limit max_line_bytes is written over the APB port at address 0.
// Throughput is one byte per cycle while the queue is not full; the
// scanner updates its state in the cycle an item is accepted.  A byte that
// ends a token and a line at once gives two items, which leave out_ch in turn.
// The scanner writes an accepted byte's items into the four-entry queue at
// the accepting edge, and the first item moves into the output register
// once that register is free.
// in_ch stays ready until the queue is full, so a stalled receiver backs
// up the queue first and then holds the input side.
// Reset clears the scan state, sets the line number to one and the limit
// to 4096, and empties the queue and the output register.
// Errors are sticky: every later item returns the same error until reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module quoted_whitespace_line_tokenizer #(
  parameter int MAX_LINE = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  qwt_in_if.sink           in_ch,
  qwt_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import qwt_pkg::*;

  logic [12:0] max_line_r;
  logic        q_push, q_pop, q_full, q_empty;
  ent_t        q_wdata, q_rdata;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_LINE_BYTES) ? 32'(max_line_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_line_r <= MAX_LINE_BYTES_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_MAX_LINE_BYTES) begin
      max_line_r <= pwdata[12:0];
    end
  end

  qwt_front #(
    .MAX_LINE(MAX_LINE)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .max_line_bytes (max_line_r),
    .in_ch          (in_ch),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  qwt_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .full  (q_full),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  qwt_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_rdata (q_rdata),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

@@ tb/quoted_whitespace_line_tokenizer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quoted whitespace line tokenizer testbench
// Sends byte items through the tokenizer and predicts every token, line end,
// end and error item from its own copy of the scan state. Well-formed random
// lines run under several line limits. A terminal case picked at random ends
// the run. Both channels stall at random.
// ----------------------------------------------------------------------------

module quoted_whitespace_line_tokenizer_tb;
  import qwt_pkg::*;

  localparam int MAX_LINE = 4096;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_BYTES = 150;
  localparam logic [2:0] LIMIT_ADDR = 3'd4 * REG_MAX_LINE_BYTES;

  typedef enum logic [2:0] {
    SCAN_BETWEEN, SCAN_UNQUOTED, SCAN_QUOTED, SCAN_AFTER_CR, SCAN_ENDED, SCAN_FAILED
  } scan_mode_e;

  typedef enum {
    FINALE_CLEAN_END, FINALE_INCOMPLETE_LINE, FINALE_OPEN_QUOTE, FINALE_LONG_LINE
  } finale_e;

  typedef struct packed {
    logic [7:0] data;
    logic       eoi;
    logic       typed;
    res_t       want;
  } stim_row_t;

  localparam stim_row_t OPENING [27] = '{
    '{"A",          1'b0, 1'b0, '0},
    '{CH_SPACE,     1'b0, 1'b1, '{KIND_TOKEN, 12'd0, 13'd1, 1'b0, 12'd0, 32'd1, '0, 1'b1}},
    '{CH_TAB,       1'b0, 1'b0, '0},
    '{CH_QUOTE,     1'b0, 1'b0, '0},
    '{"b",          1'b0, 1'b0, '0},
    '{CH_BACKSLASH, 1'b0, 1'b0, '0},
    '{CH_QUOTE,     1'b0, 1'b0, '0},
    '{CH_QUOTE,     1'b0, 1'b1, '{KIND_TOKEN, 12'd4, 13'd3, 1'b1, 12'd1, 32'd1, '0, 1'b1}},
    '{"c",          1'b0, 1'b0, '0},
    '{CH_QUOTE,     1'b0, 1'b0, '0},
    '{CH_CR,        1'b0, 1'b0, '0},
    '{CH_LF,        1'b0, 1'b0, '0},
    '{CH_LF,        1'b0, 1'b1, '{KIND_LINE_END, 12'd0, 13'd0, 1'b0, 12'd0, 32'd2, '0, 1'b1}},
    '{CH_CR,        1'b0, 1'b1, '{KIND_LINE_END, 12'd0, 13'd0, 1'b0, 12'd0, 32'd3, '0, 1'b1}},
    '{"x",          1'b0, 1'b0, '0},
    '{8'hFF,        1'b0, 1'b0, '0},
    '{8'h00,        1'b0, 1'b0, '0},
    '{CH_LF,        1'b0, 1'b0, '0},
    '{CH_QUOTE,     1'b0, 1'b0, '0},
    '{CH_QUOTE,     1'b0, 1'b1, '{KIND_TOKEN, 12'd1, 13'd0, 1'b1, 12'd0, 32'd5, '0, 1'b1}},
    '{CH_QUOTE,     1'b0, 1'b0, '0},
    '{CH_BACKSLASH, 1'b0, 1'b0, '0},
    '{CH_BACKSLASH, 1'b0, 1'b0, '0},
    '{CH_QUOTE,     1'b0, 1'b0, '0},
    '{CH_QUOTE,     1'b0, 1'b1, '{KIND_TOKEN, 12'd3, 13'd3, 1'b1, 12'd1, 32'd5, '0, 1'b1}},
    '{CH_TAB,       1'b0, 1'b0, '0},
    '{CH_LF,        1'b0, 1'b1, '{KIND_LINE_END, 12'd0, 13'd0, 1'b0, 12'd2, 32'd5, '0, 1'b1}}
  };

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  qwt_in_if  in_ch ();
  qwt_out_if out_ch ();

  quoted_whitespace_line_tokenizer dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  scan_mode_e  mode_m;
  logic [1:0]  fail_code_m;
  logic [12:0] col_m;
  logic [12:0] tok_begin_m;
  logic [12:0] line_limit_m;
  logic        escaped_m;
  logic [11:0] tok_count_m;
  logic [31:0] line_no_m;

  res_t       step_results[$];
  res_t       results_due[$];
  logic [7:0] line_text[$];
  bit         quiet;
  int         mismatches;
  int         cycle_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("quoted_whitespace_line_tokenizer test failed");
      $finish;
    end
  end

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (mismatches < 40) $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  function automatic void reset_scanner();
    mode_m = SCAN_BETWEEN;
    fail_code_m = ERR_INCOMPLETE;
    col_m = '0;
    tok_begin_m = '0;
    escaped_m = 1'b0;
    tok_count_m = '0;
    line_no_m = 32'd1;
    line_limit_m = MAX_LINE_BYTES_RESET;
  endfunction

  function automatic void emit(input logic [1:0] kind, input logic [11:0] start,
                               input logic [12:0] len, input logic q,
                               input logic [11:0] cnt, input logic [1:0] code);
    res_t r;
    r = '{kind, start, len, q, cnt, line_no_m, code, 1'b0};
    step_results.insert(step_results.size(), r);
  endfunction

  function automatic void emit_token(input logic q);
    emit(KIND_TOKEN, tok_begin_m[11:0], (col_m >= tok_begin_m) ? col_m - tok_begin_m : '0,
         q, tok_count_m, '0);
    if (tok_count_m != 12'hFFF) tok_count_m++;
  endfunction

  function automatic void emit_line_end(input logic [7:0] b);
    emit(KIND_LINE_END, '0, '0, 1'b0, tok_count_m, '0);
    if (line_no_m != 32'hFFFF_FFFF) line_no_m++;
    tok_count_m = '0;
    col_m = '0;
    mode_m = (b == CH_CR) ? SCAN_AFTER_CR : SCAN_BETWEEN;
  endfunction

  function automatic void fail_with(input logic [1:0] code);
    mode_m = SCAN_FAILED;
    fail_code_m = code;
    emit(KIND_ERROR, '0, '0, 1'b0, '0, code);
  endfunction

  function automatic void scan_byte(input logic [7:0] b, input logic eoi);
    logic eol;
    logic blank;
    step_results.delete();
    eol = (b == CH_CR) || (b == CH_LF);
    blank = (b == CH_SPACE) || (b == CH_TAB);
    if (mode_m == SCAN_FAILED) begin
      emit(KIND_ERROR, '0, '0, 1'b0, '0, fail_code_m);
    end else if (mode_m == SCAN_ENDED) begin
      if (eoi) emit(KIND_END, '0, '0, 1'b0, '0, '0);
    end else if (eoi) begin
      if ((mode_m == SCAN_BETWEEN || mode_m == SCAN_AFTER_CR) && col_m == '0) begin
        mode_m = SCAN_ENDED;
        emit(KIND_END, '0, '0, 1'b0, '0, '0);
      end else begin
        fail_with(ERR_INCOMPLETE);
      end
    end else if (mode_m == SCAN_AFTER_CR && b == CH_LF) begin
      mode_m = SCAN_BETWEEN;
    end else begin
      if (mode_m == SCAN_AFTER_CR) mode_m = SCAN_BETWEEN;
      if (!eol && col_m >= line_limit_m) begin
        fail_with(ERR_LONG);
      end else begin
        case (mode_m)
          SCAN_BETWEEN: begin
            if (eol) begin
              emit_line_end(b);
            end else if (blank) begin
              col_m++;
            end else if (b == CH_QUOTE) begin
              mode_m = SCAN_QUOTED;
              tok_begin_m = col_m + 13'd1;
              escaped_m = 1'b0;
              col_m++;
            end else begin
              mode_m = SCAN_UNQUOTED;
              tok_begin_m = col_m;
              col_m++;
            end
          end
          SCAN_UNQUOTED: begin
            if (blank) begin
              emit_token(1'b0);
              mode_m = SCAN_BETWEEN;
              col_m++;
            end else if (eol) begin
              emit_token(1'b0);
              emit_line_end(b);
            end else begin
              col_m++;
            end
          end
          default: begin
            if (eol) begin
              fail_with(ERR_QUOTE);
            end else if (b == CH_QUOTE && !escaped_m) begin
              emit_token(1'b1);
              mode_m = SCAN_BETWEEN;
              col_m++;
            end else begin
              escaped_m = (b == CH_BACKSLASH);
              col_m++;
            end
          end
        endcase
      end
    end
    if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] blank_char();
    return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = any_byte();
    while (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF || c == CH_QUOTE);
    return c;
  endfunction

  // A line never leaves a quote open and never exceeds the limit. A quoted
  // token that follows an unquoted one gets a separator, or its quote would
  // join the unquoted token and a later one could open a quote by accident.
  function automatic void compose_line(input int limit);
    logic [7:0] piece[$];
    int budget;
    bit fill;
    bit quoted_piece;
    bit after_plain;
    fill = (limit <= 48) && ($urandom_range(0, 3) == 0);
    budget = fill ? limit : $urandom_range(0, (limit < 48) ? limit : 48);
    line_text.delete();
    after_plain = 1'b0;
    if ($urandom_range(0, 4) == 0) begin
      repeat (budget) begin
        case ($urandom_range(0, 5))
          0, 1: line_text.insert(line_text.size(), blank_char());
          2: line_text.insert(line_text.size(), CH_BACKSLASH);
          default: line_text.insert(line_text.size(), plain_char());
        endcase
      end
    end else begin
      while (1) begin
        piece.delete();
        quoted_piece = ($urandom_range(0, 2) == 0);
        repeat ((quoted_piece && after_plain) ? $urandom_range(1, 2) : $urandom_range(0, 2))
          piece.insert(piece.size(), blank_char());
        if (quoted_piece) begin
          piece.insert(piece.size(), CH_QUOTE);
          repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(0, 5))
              0: piece.insert(piece.size(), CH_BACKSLASH);
              1: begin
                piece.insert(piece.size(), CH_BACKSLASH);
                piece.insert(piece.size(), CH_QUOTE);
              end
              2: piece.insert(piece.size(), blank_char());
              default: piece.insert(piece.size(), plain_char());
            endcase
          end
          if (piece[piece.size() - 1] == CH_BACKSLASH) piece.insert(piece.size(), plain_char());
          piece.insert(piece.size(), CH_QUOTE);
        end else begin
          piece.insert(piece.size(), plain_char());
          repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(0, 5))
              0: piece.insert(piece.size(), CH_QUOTE);
              1: piece.insert(piece.size(), CH_BACKSLASH);
              default: piece.insert(piece.size(), plain_char());
            endcase
          end
        end
        if (line_text.size() + piece.size() > budget) break;
        line_text = {line_text, piece};
        after_plain = !quoted_piece;
        if ($urandom_range(0, 3) == 0) break;
      end
      while (fill && line_text.size() < budget)
        line_text.insert(line_text.size(), $urandom_range(0, 1) ? blank_char() : plain_char());
    end
  endfunction

  task automatic send_item(input logic [7:0] b, input logic eoi,
                           input logic typed = 1'b0, input res_t want = '0);
    while (!quiet && $urandom_range(0, 99) < 34) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.end_of_input <= eoi;
    do @(posedge clk);
    while (in_ch.ready !== 1'b1);
    scan_byte(b, eoi);
    if (typed) results_due.insert(results_due.size(), want);
    else foreach (step_results[i]) results_due.insert(results_due.size(), step_results[i]);
  endtask

  task automatic send_line();
    foreach (line_text[i]) send_item(line_text[i], 1'b0);
    case ($urandom_range(0, 2))
      0: send_item(CH_CR, 1'b0);
      1: send_item(CH_LF, 1'b0);
      default: begin
        send_item(CH_CR, 1'b0);
        send_item(CH_LF, 1'b0);
      end
    endcase
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic check_line_limit(input logic [12:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= LIMIT_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== 32'(want)) note_mismatch("max_line_bytes readback", prdata, 32'(want));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_line_limit(input logic [12:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= LIMIT_ADDR;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (value == '0) line_limit_m = 13'd1;
    else if (value > 13'(MAX_LINE)) line_limit_m = 13'(MAX_LINE);
    else line_limit_m = value;
    check_line_limit(value);
  endtask

  task automatic check_result();
    res_t want;
    if (results_due.size() == 0) begin
      note_mismatch("result with none pending, kind", 32'(out_ch.kind), '0);
    end else begin
      want = results_due.pop_front();
      if (out_ch.kind !== want.kind)
        note_mismatch("kind", 32'(out_ch.kind), 32'(want.kind));
      if (out_ch.token_start !== want.token_start)
        note_mismatch("token_start", 32'(out_ch.token_start), 32'(want.token_start));
      if (out_ch.token_length !== want.token_length)
        note_mismatch("token_length", 32'(out_ch.token_length), 32'(want.token_length));
      if (out_ch.quoted !== want.quoted)
        note_mismatch("quoted", 32'(out_ch.quoted), 32'(want.quoted));
      if (out_ch.token_count !== want.token_count)
        note_mismatch("token_count", 32'(out_ch.token_count), 32'(want.token_count));
      if (out_ch.line_number !== want.line_number)
        note_mismatch("line_number", out_ch.line_number, want.line_number);
      if (out_ch.error_code !== want.error_code)
        note_mismatch("error_code", 32'(out_ch.error_code), 32'(want.error_code));
      if (out_ch.last !== want.last)
        note_mismatch("last", 32'(out_ch.last), 32'(want.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) check_result();
    out_ch.ready <= quiet || ($urandom_range(0, 99) >= 34);
  end

  initial begin
    logic [12:0] limits[6];
    int sent;
    finale_e finale;
    mismatches = 0;
    quiet = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.end_of_input <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    reset_scanner();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_line_limit(MAX_LINE_BYTES_RESET);

    foreach (OPENING[i])
      send_item(OPENING[i].data, OPENING[i].eoi, OPENING[i].typed, OPENING[i].want);
    settle();

    limits = '{13'd8191, 13'd0, 13'd1, 13'(MAX_LINE), 13'($urandom_range(2, 24)),
               13'($urandom_range(25, 300))};
    foreach (limits[k]) begin
      set_line_limit(limits[k]);
      quiet = (k == 0);
      sent = 0;
      while (sent < PHASE_BYTES) begin
        compose_line(line_limit_m);
        sent += line_text.size() + 1;
        send_line();
      end
      settle();
      quiet = 1'b0;
    end

    finale = finale_e'($urandom_range(0, 3));
    case (finale)
      FINALE_CLEAN_END: begin
        send_item(any_byte(), 1'b1);
        repeat (3) send_item(any_byte(), 1'b0);
      end
      FINALE_INCOMPLETE_LINE: begin
        send_item(plain_char(), 1'b0);
        send_item(blank_char(), 1'b0);
        send_item(any_byte(), 1'b1);
      end
      FINALE_OPEN_QUOTE: begin
        send_item(CH_QUOTE, 1'b0);
        send_item(plain_char(), 1'b0);
        send_item($urandom_range(0, 1) ? CH_CR : CH_LF, 1'b0);
      end
      default: begin
        set_line_limit(13'($urandom_range(1, 6)));
        repeat (line_limit_m) send_item(plain_char(), 1'b0);
        send_item($urandom_range(0, 1) ? blank_char() : plain_char(), 1'b0);
      end
    endcase
    send_item(any_byte(), 1'b1);
    send_item(any_byte(), 1'b0);
    send_item(any_byte(), 1'b0);
    settle();

    if (mismatches == 0) begin
      $display("quoted_whitespace_line_tokenizer test passed");
    end else begin
      $display("quoted_whitespace_line_tokenizer test failed");
    end
    $finish;
  end

endmodule

@@ quoted_whitespace_line_tokenizer.f @@
rtl/qwt_pkg.sv
rtl/qwt_ifs.sv
rtl/qwt_front.sv
rtl/qwt_queue.sv
rtl/qwt_back.sv
rtl/quoted_whitespace_line_tokenizer.sv
tb/quoted_whitespace_line_tokenizer_tb.sv
